// ===== rtl/core/lpht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int TABLE_SLOTS_DEF = 256;
   localparam int KEY_BYTES_DEF   = 8;
   localparam int VALUE_BITS_DEF  = 32;

   localparam logic [63:0] FNV_START = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_MULT  = 64'h00000100000001b3;

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_SCAN   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_HIT  = 3'd0,
      ST_MISS = 3'd1,
      ST_NEW  = 3'd2,
      ST_FULL = 3'd3,
      ST_END  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key_bytes;
      logic [3:0]  key_len;
      logic [31:0] new_value;
      logic [7:0]  start_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] found_key;
      logic [3:0]  found_len;
      logic [31:0] found_value;
      logic [7:0]  found_slot;
      logic [8:0]  live_entries;
   } rsp_type;

   // Classified work item handed from the front to the back end
   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] hash;
      logic [63:0] key;
      logic [3:0]  len;
      logic [31:0] value;
      logic [7:0]  start_slot;
   } work_type;

endpackage

// ===== rtl/core/lpht_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_req_if / lpht_rsp_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface lpht_req_if;
   logic valid;
   logic ready;
   logic [1:0]  action;
   logic [63:0] key_bytes;
   logic [3:0]  key_len;
   logic [31:0] new_value;
   logic [7:0]  start_slot;
   modport source (output valid, action, key_bytes, key_len, new_value, start_slot,
                   input ready);
   modport sink   (input valid, action, key_bytes, key_len, new_value, start_slot,
                   output ready);
endinterface

interface lpht_rsp_if;
   logic valid;
   logic ready;
   logic [2:0]  status;
   logic [63:0] found_key;
   logic [3:0]  found_len;
   logic [31:0] found_value;
   logic [7:0]  found_slot;
   logic [8:0]  live_entries;
   modport source (output valid, status, found_key, found_len, found_value, found_slot,
                   live_entries, input ready);
   modport sink   (input valid, status, found_key, found_len, found_value, found_slot,
                   live_entries, output ready);
endinterface

// ===== rtl/core/lpht_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_front
// Accepts a request, masks the key and hashes it with FNV-1a 64, one byte a
// cycle, then hands the work item to the queue.
// ----------------------------------------------------------------------------
module lpht_front #(
   parameter int KEY_BYTES  = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  lpht_pkg::req_type in_req,
   output logic out_valid,
   input  logic out_ready,
   output lpht_pkg::work_type out_work
);
   import lpht_pkg::*;

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [3:0] cnt_ff, cnt_in;
   work_type   work_ff, work_in;

   logic [3:0]  len_c;
   logic [63:0] key_c;
   logic [63:0] bmask;
   logic [7:0]  byte_c;
   logic [63:0] val_mask;
   logic [63:0] hx_c;
   logic [63:0] hmul_c;

   always_comb begin
      len_c = (in_req.key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_req.key_len;
      bmask = (len_c >= 4'd8) ? '1 : ((64'd1 << {len_c[2:0], 3'b000}) - 64'd1);
      key_c = in_req.key_bytes & bmask;
      val_mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
      byte_c = work_ff.key[{cnt_ff[2:0], 3'b000} +: 8];
      hx_c = work_ff.hash ^ {56'd0, byte_c};
      // FNV prime is 2^40 + 0x1b3: multiply as a sum of shifts
      hmul_c = (hx_c << 40) + (hx_c << 8) + (hx_c << 7) + (hx_c << 5)
               + (hx_c << 4) + (hx_c << 1) + hx_c;
   end

   assign in_ready  = !busy_ff;
   assign out_valid = done_ff;
   assign out_work  = work_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      if (!busy_ff) begin
         if (in_valid) begin
            busy_in            = 1'b1;
            done_in            = 1'b0;
            cnt_in             = '0;
            work_in.action     = in_req.action;
            work_in.hash       = FNV_START;
            work_in.key        = key_c;
            work_in.len        = len_c;
            work_in.value      = in_req.new_value & val_mask[31:0];
            work_in.start_slot = in_req.start_slot;
         end
      end else if (!done_ff) begin
         if (cnt_ff < work_ff.len) begin
            work_in.hash = hmul_c;
            cnt_in       = cnt_ff + 4'd1;
         end else begin
            done_in = 1'b1;
         end
      end else if (out_ready) begin
         done_in = 1'b0;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
   end
endmodule

// ===== rtl/core/lpht_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_queue
// Two-entry queue of work items between the front and back ends.
// ----------------------------------------------------------------------------
module lpht_queue (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  lpht_pkg::work_type in_work,
   output logic out_valid,
   input  logic out_ready,
   output lpht_pkg::work_type out_work
);
   import lpht_pkg::*;

   work_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_work  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_work;
   end
endmodule

// ===== rtl/core/lpht_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_back
// Executes lookup, insert, delete with backward shift, and scan against the
// slot memory, reading one slot at a time, and holds the response register.
// ----------------------------------------------------------------------------
module lpht_back #(
   parameter int TABLE_SLOTS = 256,
   parameter int VALUE_BITS  = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  lpht_pkg::work_type in_work,
   output logic out_valid,
   input  logic out_ready,
   output lpht_pkg::rsp_type out_rsp,
   output logic clearing
);
   import lpht_pkg::*;

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int CW = AW + 1;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_RD    = 8'b0000_0100,
      S_PROBE = 8'b0000_1000,
      S_SCAN  = 8'b0001_0000,
      S_DRD   = 8'b0010_0000,
      S_DCHK  = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic [63:0]           hash;
      logic [63:0]           key;
      logic [3:0]            len;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   // used bits live in a separate memory, cleared by a sweep after reset
   logic      used_mem [TABLE_SLOTS];
   entry_type ent_mem  [TABLE_SLOTS];

   state_type    st_ff, st_in;
   work_type     w_ff, w_in;
   logic [AW-1:0] idx_ff, idx_in, hole_ff, hole_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   rsp_type      rsp_ff, rsp_in;
   logic         ov_ff, ov_in;

   logic          rd_used_ff;
   entry_type     rd_ent_ff;
   logic [AW-1:0] raddr;
   logic          u_we, u_wd;
   logic [AW-1:0] u_wa;
   logic          e_we;
   logic [AW-1:0] e_wa;
   entry_type     e_wd;
   logic [AW-1:0] home;
   logic          mv;
   logic          match;

   // deferred clear of a moved entry's old slot (single used-bit write port)
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_a_ff, pend_a_in;

   always_ff @(posedge clock) begin
      rd_used_ff <= used_mem[raddr];
      rd_ent_ff  <= ent_mem[raddr];
      if (u_we) used_mem[u_wa] <= u_wd;
      if (e_we) ent_mem[e_wa] <= e_wd;
   end

   assign in_ready  = (st_ff == S_IDLE) && !ov_ff;
   assign out_valid = ov_ff;
   assign out_rsp   = rsp_ff;
   assign clearing  = st_ff == S_CLEAR;

   always_comb begin
      home  = rd_ent_ff.hash[AW-1:0];
      match = rd_ent_ff.hash == w_ff.hash && rd_ent_ff.len == w_ff.len
              && rd_ent_ff.key == w_ff.key;
      if (hole_ff < idx_ff) mv = (home <= hole_ff) || (home > idx_ff);
      else                  mv = (home <= hole_ff) && (home > idx_ff);
   end

   always_comb begin
      st_in  = st_ff;
      w_in   = w_ff;
      idx_in = idx_ff;
      hole_in = hole_ff;
      n_in   = n_ff;
      cnt_in = cnt_ff;
      rsp_in = rsp_ff;
      ov_in  = ov_ff;
      raddr  = idx_ff;
      u_we = 1'b0; u_wa = idx_ff; u_wd = 1'b0;
      e_we = 1'b0; e_wa = idx_ff; e_wd = rd_ent_ff;
      if (ov_ff && out_ready) ov_in = 1'b0;
      unique case (st_ff)
         S_CLEAR: begin
            u_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == AW'(TABLE_SLOTS - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (in_valid && !ov_ff) begin
               w_in = in_work;
               n_in = '0;
               rsp_in = '0;
               rsp_in.status = ST_MISS;
               if (in_work.action == ACT_SCAN) begin
                  if ({8'd0, in_work.start_slot} >= 16'(TABLE_SLOTS)) begin
                     rsp_in.status = ST_END;
                     rsp_in.live_entries = 9'(cnt_ff);
                     ov_in = 1'b1;
                  end else begin
                     idx_in = AW'(in_work.start_slot);
                     st_in = S_RD;
                  end
               end else begin
                  idx_in = in_work.hash[AW-1:0];
                  st_in = S_RD;
               end
            end
         end
         S_RD: st_in = (w_ff.action == ACT_SCAN) ? S_SCAN : S_PROBE;
         S_SCAN: begin
            if (rd_used_ff) begin
               rsp_in.status = ST_HIT;
               rsp_in.found_key = rd_ent_ff.key;
               rsp_in.found_len = rd_ent_ff.len;
               rsp_in.found_value = 32'(rd_ent_ff.value);
               rsp_in.found_slot = 8'(idx_ff);
               st_in = S_OUT;
            end else if (idx_ff == AW'(TABLE_SLOTS - 1)) begin
               rsp_in.status = ST_END;
               st_in = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
               st_in = S_RD;
            end
         end
         S_PROBE: begin
            priority if (!rd_used_ff || n_ff == CW'(TABLE_SLOTS - 1) && !match) begin
               // empty slot or table exhausted
               if (w_ff.action == ACT_INSERT) begin
                  if ((CW+2)'({cnt_ff + 1'b1, 2'b00}) >= (CW+2)'(TABLE_SLOTS * 3)
                      || rd_used_ff) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     u_we = 1'b1; u_wd = 1'b1;
                     e_we = 1'b1;
                     e_wd.hash = w_ff.hash; e_wd.key = w_ff.key;
                     e_wd.len = w_ff.len; e_wd.value = VALUE_BITS'(w_ff.value);
                     cnt_in = cnt_ff + 1'b1;
                     rsp_in.status = ST_NEW;
                     rsp_in.found_slot = 8'(idx_ff);
                  end
               end
               st_in = S_OUT;
            end else if (match) begin
               rsp_in.status = ST_HIT;
               rsp_in.found_slot = 8'(idx_ff);
               if (w_ff.action == ACT_LOOKUP) begin
                  rsp_in.found_value = 32'(rd_ent_ff.value);
                  st_in = S_OUT;
               end else if (w_ff.action == ACT_INSERT) begin
                  e_we = 1'b1;
                  e_wd.value = VALUE_BITS'(w_ff.value);
                  st_in = S_OUT;
               end else begin
                  u_we = 1'b1; u_wd = 1'b0;
                  cnt_in = cnt_ff - 1'b1;
                  hole_in = idx_ff;
                  idx_in = idx_ff + 1'b1;
                  n_in = '0;
                  st_in = S_DRD;
               end
            end else begin
               n_in = n_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               st_in = S_RD;
            end
         end
         S_DRD: st_in = S_DCHK;
         S_DCHK: begin
            if (!rd_used_ff || n_ff == CW'(TABLE_SLOTS - 1)) begin
               st_in = S_OUT;
            end else begin
               if (mv) begin
                  // shift entry back into the hole
                  u_we = 1'b1; u_wa = hole_ff; u_wd = 1'b1;
                  e_we = 1'b1; e_wa = hole_ff; e_wd = rd_ent_ff;
                  hole_in = idx_ff;
               end
               n_in = n_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               st_in = S_DRD;
            end
         end
         S_OUT: begin
            rsp_in.live_entries = 9'(cnt_ff);
            ov_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      // the vacated source slot is cleared in the following S_DRD state via a registered pending write
      if (st_ff == S_DRD && pend_ff) begin
         u_we = 1'b1; u_wa = pend_a_ff; u_wd = 1'b0;
      end
   end

   always_comb begin
      pend_in   = (st_ff == S_DCHK) && rd_used_ff && (n_ff != CW'(TABLE_SLOTS - 1)) && mv;
      pend_a_in = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_CLEAR;
         idx_ff <= '0;
         cnt_ff <= '0;
         ov_ff  <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
         ov_ff  <= ov_in;
         pend_ff <= pend_in;
      end
      w_ff    <= w_in;
      hole_ff <= hole_in;
      n_ff    <= n_in;
      rsp_ff  <= rsp_in;
      pend_a_ff <= pend_a_in;
   end
endmodule

// ===== rtl/core/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
// Flow: the front hashes the key byte by byte, then queues the work item; the
// back end reads each slot in S_RD/S_DRD and acts on it in S_PROBE, S_SCAN or
// S_DCHK, then S_OUT loads the response. One transaction at a time in the back
// end; the front hashes the next key while the back end works.
// Reset: synchronous; after reset a sweep over all TABLE_SLOTS slots clears
// the slot-used marks, during which no request is accepted.
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing key-value table with FNV-1a 64 hashing and linear probing.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
   parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF,
   parameter int VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF
) (
   input logic clock,
   input logic reset,
   lpht_req_if.sink   req,
   lpht_rsp_if.source rsp
);
   import lpht_pkg::*;

   req_type  req_c;
   work_type f_work, q_work;
   rsp_type  b_rsp;
   logic f_valid, f_ready, q_valid, q_ready, clearing;
   logic req_ready_c;

   assign req_c.action     = req.action;
   assign req_c.key_bytes  = req.key_bytes;
   assign req_c.key_len    = req.key_len;
   assign req_c.new_value  = req.new_value;
   assign req_c.start_slot = req.start_slot;
   assign req.ready = req_ready_c && !clearing;

   lpht_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_front (
      .clock, .reset,
      .in_valid(req.valid && !clearing), .in_ready(req_ready_c), .in_req(req_c),
      .out_valid(f_valid), .out_ready(f_ready), .out_work(f_work)
   );

   lpht_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_work(f_work),
      .out_valid(q_valid), .out_ready(q_ready), .out_work(q_work)
   );

   lpht_back #(.TABLE_SLOTS(TABLE_SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_work(q_work),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rsp(b_rsp),
      .clearing
   );

   assign rsp.status       = b_rsp.status;
   assign rsp.found_key    = b_rsp.found_key;
   assign rsp.found_len    = b_rsp.found_len;
   assign rsp.found_value  = b_rsp.found_value;
   assign rsp.found_slot   = b_rsp.found_slot;
   assign rsp.live_entries = b_rsp.live_entries;

   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req.ready) else $error("request taken during clear");
   a_live_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.live_entries <= 9'(TABLE_SLOTS)) else $error("count overflow");
   a_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.status <= ST_END) else $error("bad status");
endmodule
